[hdl/csf_pkg.sv]
// csf_pkg: shared types and constants for the cross stencil smoothing filter
// no dependencies; imported by the stream interface users and all csf modules
`timescale 1ns / 1ps

package csf_pkg;

  localparam int PIXEL_W = 8;
  localparam int INDEX_W = 10;
  // 4*c + n + s + w + e of 8-bit pixels fits in 11 bits
  localparam int SUM_W = PIXEL_W + 3;
  // centre weight of 4
  localparam int CENTRE_SHIFT = 2;
  // divide by 8
  localparam int NORM_SHIFT = 3;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [INDEX_W-1:0] index_t;

  typedef struct packed {
    pixel_t in_pixel;
  } in_item_t;

  typedef struct packed {
    pixel_t out_pixel;
    index_t out_index;
    logic   frame_last;
  } out_item_t;

  // cross neighborhood around the pixel being emitted
  typedef struct packed {
    pixel_t north;
    pixel_t south;
    pixel_t west;
    pixel_t centre;
    pixel_t east;
  } window_t;

  typedef struct packed {
    logic flush;   // last-row pixel, value sits in the north slot
    logic border;  // first row or first/last column, centre passes through
  } stencil_ctl_t;

endpackage

[hdl/csf_stream_if.sv]
// csf_stream_if: valid/ready stream channel with a typed payload
// payload type is a parameter, normally a struct from csf_pkg
`timescale 1ns / 1ps

interface csf_stream_if #(
  parameter type data_t = logic
) ();

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

[hdl/csf_line_buffer.sv]
// csf_line_buffer: pixel history ring, one write and two registered read ports
// depends on csf_pkg for the pixel type
`timescale 1ns / 1ps

module csf_line_buffer #(
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  csf_pkg::pixel_t   wr_data,
  input  logic              rd_a_en,
  input  logic [ADDR_W-1:0] rd_a_addr,
  output csf_pkg::pixel_t   rd_a_data,
  input  logic              rd_b_en,
  input  logic [ADDR_W-1:0] rd_b_addr,
  output csf_pkg::pixel_t   rd_b_data
);
  import csf_pkg::*;

  pixel_t mem [DEPTH];

  // read before write on a shared address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

[hdl/csf_stencil.sv]
// csf_stencil: weighted cross sum and border / flush selection
// depends on csf_pkg for window and control structs
`timescale 1ns / 1ps

module csf_stencil (
  input  csf_pkg::window_t      win,
  input  csf_pkg::stencil_ctl_t ctl,
  output csf_pkg::pixel_t       result
);
  import csf_pkg::*;

  logic [SUM_W-1:0] sum;

  assign sum = (SUM_W'(win.centre) << CENTRE_SHIFT) + SUM_W'(win.north) + SUM_W'(win.south)
             + SUM_W'(win.west) + SUM_W'(win.east);

  always_comb begin
    if (ctl.flush) begin
      result = win.north;
    end else if (ctl.border) begin
      result = win.centre;
    end else begin
      result = sum[NORM_SHIFT +: PIXEL_W];
    end
  end

endmodule

[hdl/cross_stencil_smoothing_filter.sv]
// cross_stencil_smoothing_filter: top level, counters, flush sequencer, pipeline
// depends on csf_pkg, csf_stream_if, csf_line_buffer and csf_stencil
`timescale 1ns / 1ps

// usage
// - pixels: one 8-bit grayscale pixel per transfer, raster order, frames of
//   IMAGE_WIDTH x IMAGE_HEIGHT back to back
// - smoothed: one result per transfer: pixel, raster index (mod 1024) and a
//   frame_last flag on the final pixel of each frame
// - pixel p leaves once pixel p + IMAGE_WIDTH has been taken, so output trails
//   input by one row; an emitted pixel passes through the input stage and then
//   the output register after the transfer that releases it
// - throughput is one pixel per cycle while smoothed is ready, set by the
//   stage-to-stage handshake and the history ring's two read ports (east, north)
// - the last pixel of a frame starts a flush of the last row: IMAGE_WIDTH
//   results, one per cycle while smoothed is ready, via the ring's north port;
//   pixels.ready stays low until the flush ends, then the next frame starts at 0
// - interior pixels: (4*c + n + s + w + e) >> 3; border rows and columns pass
// - a stall on smoothed holds the output register; the input stage keeps
//   taking pixels until it holds an item that cannot move on
// - rst (synchronous, active high) clears the position, flush and valid state;
//   the ring needs no clearing, every pixel that matters is written first
module cross_stencil_smoothing_filter #(
  parameter int IMAGE_WIDTH  = 32,
  parameter int IMAGE_HEIGHT = 32
) (
  input logic          clk,
  input logic          rst,
  csf_stream_if.sink   pixels,
  csf_stream_if.source smoothed
);
  import csf_pkg::*;

  localparam int HIST_DEPTH = 2 * IMAGE_WIDTH;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int COL_W      = $clog2(IMAGE_WIDTH);
  localparam int ROW_W      = $clog2(IMAGE_HEIGHT);

  // input position
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [HA_W-1:0]  wp;        // ring slot of the incoming pixel
  logic [HA_W-1:0]  wp_inc;
  logic [HA_W:0]    ep_sum;
  logic [HA_W-1:0]  ep;        // ring slot of the east neighbor, pos - width + 1

  // last-row flush
  logic             flushing;
  logic [COL_W-1:0] fcnt;
  logic [HA_W-1:0]  faddr;
  logic [HA_W-1:0]  faddr_inc;

  // handshakes
  logic in_fire;
  logic flush_issue;
  logic s1_free;
  logic s1_advance;
  logic out_load;
  logic frame_end;
  logic emit_in;
  logic flush_final;

  // input stage
  logic         s1_valid;
  logic         s1_emit;
  logic         s1_flush;
  logic         s1_border;
  logic         s1_last;
  index_t       s1_idx;
  pixel_t       s1_south;
  pixel_t       centre;
  pixel_t       west;
  index_t       oidx;
  pixel_t       rd_east;
  pixel_t       rd_north;
  window_t      win;
  stencil_ctl_t ctl;
  pixel_t       result;

  // output register
  logic      out_valid;
  out_item_t out_data;

  assign in_fire     = pixels.valid && pixels.ready;
  assign s1_advance  = s1_valid && (!s1_emit || !out_valid || smoothed.ready);
  assign s1_free     = !s1_valid || s1_advance;
  assign pixels.ready = s1_free && !flushing;
  assign flush_issue = flushing && s1_free;
  assign out_load    = s1_advance && s1_emit;

  assign frame_end   = (row == ROW_W'(IMAGE_HEIGHT - 1)) && (col == COL_W'(IMAGE_WIDTH - 1));
  assign emit_in     = in_fire && (row != '0);
  assign flush_final = flush_issue && (fcnt == COL_W'(IMAGE_WIDTH - 1));

  assign wp_inc    = (wp == HA_W'(HIST_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign faddr_inc = (faddr == HA_W'(HIST_DEPTH - 1)) ? '0 : faddr + 1'b1;
  assign ep_sum    = {1'b0, wp} + (HA_W + 1)'(IMAGE_WIDTH + 1);
  assign ep        = (ep_sum >= (HA_W + 1)'(HIST_DEPTH)) ?
                     HA_W'(ep_sum - (HA_W + 1)'(HIST_DEPTH)) : ep_sum[HA_W-1:0];

  // position counters and flush sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      wp       <= '0;
      flushing <= 1'b0;
      fcnt     <= '0;
      faddr    <= '0;
    end else begin
      if (in_fire) begin
        if (frame_end) begin
          col      <= '0;
          row      <= '0;
          wp       <= '0;
          flushing <= 1'b1;
          fcnt     <= '0;
          faddr    <= ep;  // first pixel of the last row
        end else begin
          wp <= wp_inc;
          if (col == COL_W'(IMAGE_WIDTH - 1)) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
      end
      if (flush_issue) begin
        faddr <= faddr_inc;
        fcnt  <= fcnt + 1'b1;
        if (flush_final) begin
          flushing <= 1'b0;
        end
      end
    end
  end

  // north port doubles as the flush read port; the two never overlap
  csf_line_buffer #(
    .DEPTH(HIST_DEPTH)
  ) u_line_buffer (
    .clk      (clk),
    .wr_en    (in_fire),
    .wr_addr  (wp),
    .wr_data  (pixels.data.in_pixel),
    .rd_a_en  (in_fire),
    .rd_a_addr(ep),
    .rd_a_data(rd_east),
    .rd_b_en  (in_fire || flush_issue),
    .rd_b_addr(flushing ? faddr : wp),
    .rd_b_data(rd_north)
  );

  // input stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
      oidx     <= '0;
    end else begin
      if (in_fire || flush_issue) begin
        s1_valid <= 1'b1;
        s1_emit  <= flush_issue || (row != '0);
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (emit_in || flush_issue) begin
        oidx <= flush_final ? '0 : oidx + 1'b1;
      end
    end
  end

  // input stage payload; the west/centre taps shift only with input pixels
  always_ff @(posedge clk) begin
    if (in_fire || flush_issue) begin
      s1_flush  <= flush_issue;
      s1_border <= (row == ROW_W'(1)) || (col == '0) || (col == COL_W'(IMAGE_WIDTH - 1));
      s1_last   <= flush_final;
      s1_idx    <= oidx;
    end
    if (in_fire) begin
      s1_south <= pixels.data.in_pixel;
      centre   <= rd_east;
      west     <= centre;
    end
  end

  assign win.north  = rd_north;
  assign win.south  = s1_south;
  assign win.west   = west;
  assign win.centre = centre;
  assign win.east   = rd_east;
  assign ctl.flush  = s1_flush;
  assign ctl.border = s1_border;

  csf_stencil u_stencil (
    .win   (win),
    .ctl   (ctl),
    .result(result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (smoothed.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_pixel  <= result;
      out_data.out_index  <= s1_idx;
      out_data.frame_last <= s1_last;
    end
  end

  assign smoothed.valid = out_valid;
  assign smoothed.data  = out_data;

endmodule

[bench/tb_cross_stencil_smoothing_filter.sv]
// tb_cross_stencil_smoothing_filter: self-checking bench for the cross stencil smoothing filter
// depends on csf_pkg, csf_stream_if and cross_stencil_smoothing_filter
// scripted opening rows, then random pixels checked against a behavioral predictor
`timescale 1ns / 1ps

module tb_cross_stencil_smoothing_filter;

  import csf_pkg::*;

  // frame geometry, kept at the block defaults
  localparam int W = 32;
  localparam int H = 32;
  localparam int unsigned FRAME = W * H;
  // two rows of history, same depth as the block's ring
  localparam int unsigned RING = 2 * W;
  // scripted rows plus random pixels, a good part of the first frame
  localparam int unsigned TOTAL_PIXELS = 420;
  // extra watch once nothing is owed: pipeline plus one flushed row
  localparam int unsigned DRAIN_CYCLES = W + 16;
  // far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned REPORT_MAX = 10;

  // content styles for the random pixels
  typedef enum logic [1:0] {
    FILL_UNIFORM,
    FILL_EXTREMES,
    FILL_FLAT,
    FILL_ONE_HOT
  } fill_style_t;

  // one scripted row: a pixel value repeated run times; where typed is set,
  // the smoothed pixel released by each of these transfers is known by eye
  typedef struct packed {
    pixel_t     value;
    logic [5:0] run;
    logic       typed;
    pixel_t     want;
  } script_row_t;

  // rows 0..4 of the first frame
  // - row 0: extremes and alternating bit patterns, then a run of 255
  // - row 1: all zero; releases row 0, which is a border row and passes through
  // - rows 2 and 3: all 255, interior results come from the predictor
  // - row 4: all 255; releases row 3, whose whole cross is 255, so every
  //   output is 255 (largest possible sum)
  localparam script_row_t SCRIPT [21] = '{
    '{8'h00, 6'd1,  1'b0, 8'h00},
    '{8'hff, 6'd1,  1'b0, 8'h00},
    '{8'h55, 6'd1,  1'b0, 8'h00},
    '{8'haa, 6'd1,  1'b0, 8'h00},
    '{8'h01, 6'd1,  1'b0, 8'h00},
    '{8'h80, 6'd1,  1'b0, 8'h00},
    '{8'hfe, 6'd1,  1'b0, 8'h00},
    '{8'h7f, 6'd1,  1'b0, 8'h00},
    '{8'hff, 6'd24, 1'b0, 8'h00},
    '{8'h00, 6'd1,  1'b1, 8'h00},
    '{8'h00, 6'd1,  1'b1, 8'hff},
    '{8'h00, 6'd1,  1'b1, 8'h55},
    '{8'h00, 6'd1,  1'b1, 8'haa},
    '{8'h00, 6'd1,  1'b1, 8'h01},
    '{8'h00, 6'd1,  1'b1, 8'h80},
    '{8'h00, 6'd1,  1'b1, 8'hfe},
    '{8'h00, 6'd1,  1'b1, 8'h7f},
    '{8'h00, 6'd24, 1'b1, 8'hff},
    '{8'hff, 6'd32, 1'b0, 8'h00},
    '{8'hff, 6'd32, 1'b0, 8'h00},
    '{8'hff, 6'd32, 1'b1, 8'hff}
  };

  logic clk = 1'b0;
  logic rst;

  csf_stream_if #(.data_t(in_item_t))  pixels ();
  csf_stream_if #(.data_t(out_item_t)) smoothed ();

  cross_stencil_smoothing_filter #(
    .IMAGE_WIDTH  (W),
    .IMAGE_HEIGHT (H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixels),
    .smoothed (smoothed)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: its own copy of the two-row ring and the raster position
  pixel_t      hist_ring [RING];
  int unsigned raster_pos;
  // smoothed pixels owed by the block, oldest first
  out_item_t   pending_smoothed [$];

  int unsigned mismatch_count;
  int unsigned pixels_sent;
  int unsigned cycle_count;
  int unsigned sink_hold;
  // when set, neither side idles
  bit          steady;

  // gap length for either side: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic pixel_t pick_pixel(fill_style_t style);
    case (style)
      FILL_EXTREMES: begin
        return ($urandom_range(1) == 1) ? 8'hff : 8'h00;
      end
      FILL_FLAT: begin
        return pixel_t'($urandom_range(131, 124));
      end
      FILL_ONE_HOT: begin
        return pixel_t'(1 << $urandom_range(7));
      end
      default: begin
        return pixel_t'($urandom);
      end
    endcase
  endfunction

  // cross stencil at raster position p, with the just-arrived pixel as south;
  // border rows and columns pass the centre through
  function automatic pixel_t smooth_at(int unsigned p, pixel_t south);
    int unsigned     row;
    int unsigned     col;
    logic [SUM_W-1:0] sum;
    row = p / W;
    col = p % W;
    if (row == 0 || row >= H - 1 || col == 0 || col == W - 1)
      return hist_ring[p % RING];
    sum = (SUM_W'(hist_ring[p % RING]) << CENTRE_SHIFT)
        + SUM_W'(hist_ring[(p - W) % RING])
        + SUM_W'(south)
        + SUM_W'(hist_ring[(p - 1) % RING])
        + SUM_W'(hist_ring[(p + 1) % RING]);
    return pixel_t'(sum >> NORM_SHIFT);
  endfunction

  // advance the predictor by one accepted pixel and queue what it releases;
  // a typed row overrides only the smoothed value of the stencil result
  function automatic void take_pixel(pixel_t pix, bit typed, pixel_t want);
    int unsigned pos;
    int unsigned p;
    out_item_t   r;
    pos = raster_pos;
    if (pos >= FRAME) pos = 0;
    // the pixel one row up is complete once its south neighbor arrives
    if (pos >= W) begin
      p = pos - W;
      r.out_pixel  = typed ? want : smooth_at(p, pix);
      r.out_index  = index_t'(p);
      r.frame_last = (p == FRAME - 1);
      pending_smoothed.push_back(r);
    end
    // the ring slot is overwritten only after the north read above
    hist_ring[pos % RING] = pix;
    if (pos == FRAME - 1) begin
      // frame end: the whole last row leaves unchanged, last one flagged
      for (p = pos - W + 1; p <= pos; p++) begin
        r.out_pixel  = hist_ring[p % RING];
        r.out_index  = index_t'(p);
        r.frame_last = (p == pos);
        pending_smoothed.push_back(r);
      end
      raster_pos = 0;
    end else begin
      raster_pos = pos + 1;
    end
  endfunction

  // one pixel transfer: optional idle stretch, then hold valid until ready
  task automatic send_pixel(input pixel_t value, input bit typed, input pixel_t want);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      // idle cycles carry junk data so stale payload is never relied on
      pixels.valid         <= 1'b0;
      pixels.data.in_pixel <= pixel_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    pixels.valid         <= 1'b1;
    pixels.data.in_pixel <= value;
    do @(posedge clk); while (!pixels.ready);
    take_pixel(value, typed, want);
    pixels_sent++;
  endtask

  task automatic note_mismatch(input string what, input out_item_t want,
                               input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("[%0d] %s: expected pixel %0d index %0d last %0b, got pixel %0d index %0d last %0b",
               cycle_count, what, want.out_pixel, want.out_index, want.frame_last,
               got.out_pixel, got.out_index, got.frame_last);
  endtask

  // output checker: every transfer on the result side is matched, in order,
  // against the oldest owed result
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst && smoothed.valid && smoothed.ready) begin
      got = smoothed.data;
      if (pending_smoothed.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_smoothed.pop_front();
        if (got.out_pixel !== want.out_pixel || got.out_index !== want.out_index ||
            got.frame_last !== want.frame_last)
          note_mismatch("wrong result", want, got);
      end
    end
  end

  // result side back-pressure: random stalls, none while steady
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      smoothed.ready <= 1'b0;
      sink_hold--;
    end else begin
      smoothed.ready <= 1'b1;
      sink_hold = pick_gap();
    end
  end

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending_smoothed.size());
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus and end of run
  initial begin
    fill_style_t style;
    style            = FILL_UNIFORM;
    rst              = 1'b1;
    pixels.valid     = 1'b0;
    pixels.data      = '0;
    smoothed.ready   = 1'b0;
    sink_hold        = 0;
    steady           = 1'b0;
    raster_pos       = 0;
    mismatch_count   = 0;
    pixels_sent      = 0;
    cycle_count      = 0;
    foreach (hist_ring[i]) hist_ring[i] = '0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // scripted opening rows of the first frame
    foreach (SCRIPT[i]) begin
      for (int k = 0; k < SCRIPT[i].run; k++)
        send_pixel(SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // random content for the rest of the run;
    // style and idling change every 128 pixels
    while (pixels_sent < TOTAL_PIXELS) begin
      if (pixels_sent % 128 == 0) begin
        style  = fill_style_t'($urandom_range(3));
        steady = ($urandom_range(3) == 0);
      end
      send_pixel(pick_pixel(style), 1'b0, '0);
    end

    @(negedge clk);
    pixels.valid <= 1'b0;
    steady       = 1'b0;

    // drain what is owed, then watch a little longer for strays
    while (pending_smoothed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
